>>> hdl/dbd_pkg.sv
// ----------------------------------------------------------------------------
// dbd_pkg: shared types and constants for the detector box decoder
// Field widths, register indexes, register reset values and the pipeline
// control bundle handed to the per-axis datapath.
// ----------------------------------------------------------------------------
package dbd_pkg;

	localparam int MAX_CLASSES_DEF = 128;

	localparam int COORD_W    = 16;  // Q12.4 center and size
	localparam int SCORE_W    = 16;  // Q0.16 class score
	localparam int SCALE_W    = 16;  // Q8.8 scale factor
	localparam int FRAME_W    = 14;  // frame size in pixels
	localparam int EDGE_W     = 13;  // left / top
	localparam int LEN_W      = 14;  // width / height
	localparam int CLASS_ID_W = 7;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam int S_DATA_W = 80;
	localparam int M_DATA_W = 80;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_CONF_LIMIT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_W    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_H    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_X    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y    = 3'd4;

	localparam logic [SCORE_W-1:0] CONF_LIMIT_RST = 16'd16384;
	localparam logic [FRAME_W-1:0] FRAME_W_RST    = 14'd640;
	localparam logic [FRAME_W-1:0] FRAME_H_RST    = 14'd640;
	localparam logic [SCALE_W-1:0] SCALE_X_RST    = 16'd256;
	localparam logic [SCALE_W-1:0] SCALE_Y_RST    = 16'd256;

	// Frame sizes above this act as this
	localparam logic [FRAME_W-1:0] FRAME_MAX = 14'd8192;

	typedef struct packed {
		logic ld_s2;
		logic ld_s3;
		logic ld_out;
	} pipe_ctl_t;

endpackage

>>> hdl/dbd_axis.sv
// ----------------------------------------------------------------------------
// dbd_axis: one axis of the box transform
// Scales the box start edge and extent into frame pixels, truncates toward
// zero and clamps both into the frame. Three register stages.
// ----------------------------------------------------------------------------
module dbd_axis (
	input  logic                                   clk,
	input  dbd_pkg::pipe_ctl_t                     ctl,
	input  logic signed [dbd_pkg::COORD_W-1:0]     center,
	input  logic signed [dbd_pkg::COORD_W-1:0]     size,
	input  logic        [dbd_pkg::SCALE_W-1:0]     scale,
	input  logic        [dbd_pkg::FRAME_W-1:0]     frame,
	output logic        [dbd_pkg::EDGE_W-1:0]      edge_pos,
	output logic        [dbd_pkg::LEN_W-1:0]       length
);

	// 2*center - size in Q.4, that is center - size/2 in Q.5
	logic signed [17:0] diff;
	logic signed [34:0] pe_s2;
	logic signed [32:0] pl_s2;

	logic signed [34:0] pe_rnd;
	logic signed [32:0] pl_rnd;
	logic signed [21:0] e_div;
	logic signed [20:0] l_div;
	logic [dbd_pkg::FRAME_W-1:0] f_lim;
	logic [dbd_pkg::FRAME_W-1:0] f_m1;
	logic [dbd_pkg::EDGE_W-1:0]  e_clamp;

	logic [dbd_pkg::EDGE_W-1:0]  edge_s3;
	logic signed [20:0]          len_s3;
	logic [dbd_pkg::FRAME_W-1:0] f_s3;

	logic [dbd_pkg::FRAME_W-1:0] rem;
	logic [dbd_pkg::LEN_W-1:0]   len_c;

	assign diff = {center[15], center, 1'b0} - {{2{size[15]}}, size};

	always_ff @(posedge clk) begin
		if (ctl.ld_s2) begin
			pe_s2 <= diff * $signed({1'b0, scale});
			pl_s2 <= size * $signed({1'b0, scale});
		end
	end

	// Truncate toward zero: bias negatives before the arithmetic shift
	assign pe_rnd = pe_s2 + (pe_s2[34] ? 35'sd8191 : 35'sd0);
	assign pl_rnd = pl_s2 + (pl_s2[32] ? 33'sd4095 : 33'sd0);
	assign e_div  = $signed(pe_rnd[34:13]);
	assign l_div  = $signed(pl_rnd[32:12]);

	assign f_lim = (frame > dbd_pkg::FRAME_MAX) ? dbd_pkg::FRAME_MAX : frame;
	assign f_m1  = (f_lim == '0) ? '0 : f_lim - 14'd1;

	always_comb begin
		if (e_div[21])
			e_clamp = '0;
		else if (e_div > $signed({8'b0, f_m1}))
			e_clamp = f_m1[12:0];
		else
			e_clamp = e_div[12:0];
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_s3) begin
			edge_s3 <= e_clamp;
			len_s3  <= l_div;
			f_s3    <= f_lim;
		end
	end

	// Extent is capped by what is left of the frame, then floored at one
	assign rem = f_s3 - {1'b0, edge_s3};

	always_comb begin
		if (len_s3 > $signed({7'b0, rem}))
			len_c = (rem == '0) ? 14'd1 : rem;
		else if (len_s3 < 21'sd1)
			len_c = 14'd1;
		else
			len_c = len_s3[13:0];
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_out) begin
			edge_pos <= edge_s3;
			length   <= len_c;
		end
	end

endmodule

>>> hdl/detector_box_decode.sv
// ----------------------------------------------------------------------------
// detector_box_decode: detector output decoder, top level
// Running argmax over class scores per box, threshold test and box scaling
// into frame pixels.
// ----------------------------------------------------------------------------
// One class score beat is taken per cycle while the first stage has room,
// with no gaps between boxes. The argmax updates in the accept cycle; the
// beat flagged tlast closes the box and, when its best score is above
// confidence_limit, enters a four-stage path (input register, multiply,
// truncate and edge clamp, extent clamp and result register); m_tvalid
// rises when the result register loads. Back-pressure on the result side
// stalls only the occupied stages; beats that do not close a box are always
// taken while the first stage has room.
module detector_box_decode #(
	parameter int MAX_CLASSES = dbd_pkg::MAX_CLASSES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// center_x[15:0], center_y[31:16], box_w[47:32], box_h[63:48], class_score[79:64]
	input  logic [dbd_pkg::S_DATA_W-1:0]      s_tdata,
	input  logic                              s_tlast,   // last_class
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// left[12:0], top[25:13], width[39:26], height[53:40], score[69:54],
	// class_id[76:70], zero[79:77]
	output logic [dbd_pkg::M_DATA_W-1:0]      m_tdata,
	input  logic                              cfg_we,
	input  logic [dbd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [dbd_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int CNT_W = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_CLASSES - 1);

	// configuration
	logic [dbd_pkg::SCORE_W-1:0] conf_limit_q;
	logic [dbd_pkg::FRAME_W-1:0] frame_w_q;
	logic [dbd_pkg::FRAME_W-1:0] frame_h_q;
	logic [dbd_pkg::SCALE_W-1:0] scale_x_q;
	logic [dbd_pkg::SCALE_W-1:0] scale_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conf_limit_q <= dbd_pkg::CONF_LIMIT_RST;
			frame_w_q    <= dbd_pkg::FRAME_W_RST;
			frame_h_q    <= dbd_pkg::FRAME_H_RST;
			scale_x_q    <= dbd_pkg::SCALE_X_RST;
			scale_y_q    <= dbd_pkg::SCALE_Y_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				dbd_pkg::REG_CONF_LIMIT: conf_limit_q <= cfg_data;
				dbd_pkg::REG_FRAME_W:    frame_w_q    <= cfg_data[dbd_pkg::FRAME_W-1:0];
				dbd_pkg::REG_FRAME_H:    frame_h_q    <= cfg_data[dbd_pkg::FRAME_W-1:0];
				dbd_pkg::REG_SCALE_X:    scale_x_q    <= cfg_data;
				dbd_pkg::REG_SCALE_Y:    scale_y_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// input fields
	logic signed [dbd_pkg::COORD_W-1:0] in_cx, in_cy, in_bw, in_bh;
	logic [dbd_pkg::SCORE_W-1:0]        in_score;

	assign in_cx    = $signed(s_tdata[15:0]);
	assign in_cy    = $signed(s_tdata[31:16]);
	assign in_bw    = $signed(s_tdata[47:32]);
	assign in_bh    = $signed(s_tdata[63:48]);
	assign in_score = s_tdata[79:64];

	// running argmax
	logic [dbd_pkg::SCORE_W-1:0] best_q;
	logic [CNT_W-1:0]            best_cls_q;
	logic [CNT_W-1:0]            cnt_q;
	logic                        acc;
	logic                        gt;
	logic [dbd_pkg::SCORE_W-1:0] best_nx;
	logic [CNT_W-1:0]            cls_nx;
	logic                        pass;

	assign acc     = s_tvalid && s_tready;
	assign gt      = in_score > best_q;
	assign best_nx = gt ? in_score : best_q;
	assign cls_nx  = gt ? cnt_q : best_cls_q;
	assign pass    = best_nx > conf_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q     <= '0;
			best_cls_q <= '0;
			cnt_q      <= '0;
		end else if (acc) begin
			if (s_tlast) begin
				best_q     <= '0;
				best_cls_q <= '0;
				cnt_q      <= '0;
			end else begin
				best_q     <= best_nx;
				best_cls_q <= cls_nx;
				if (cnt_q != CNT_LAST)
					cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// pipeline control: each stage moves when the next one has room
	logic v1_q, v2_q, v3_q, vo_q;
	logic ld1;
	dbd_pkg::pipe_ctl_t ctl;

	assign ctl.ld_out = v3_q && (!vo_q || m_tready);
	assign ctl.ld_s3  = v2_q && (!v3_q || ctl.ld_out);
	assign ctl.ld_s2  = v1_q && (!v2_q || ctl.ld_s3);
	assign s_tready   = !v1_q || ctl.ld_s2;
	assign ld1        = acc && s_tlast && pass;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			vo_q <= 1'b0;
		end else begin
			if (ld1)
				v1_q <= 1'b1;
			else if (ctl.ld_s2)
				v1_q <= 1'b0;
			if (ctl.ld_s2)
				v2_q <= 1'b1;
			else if (ctl.ld_s3)
				v2_q <= 1'b0;
			if (ctl.ld_s3)
				v3_q <= 1'b1;
			else if (ctl.ld_out)
				v3_q <= 1'b0;
			if (ctl.ld_out)
				vo_q <= 1'b1;
			else if (m_tready)
				vo_q <= 1'b0;
		end
	end

	// payload
	logic signed [dbd_pkg::COORD_W-1:0] cx_s1, cy_s1, bw_s1, bh_s1;
	logic [dbd_pkg::SCORE_W-1:0]        score_s1, score_s2, score_s3, score_q;
	logic [CNT_W-1:0]                   cls_s1, cls_s2, cls_s3, cls_q;

	always_ff @(posedge clk) begin
		if (ld1) begin
			cx_s1    <= in_cx;
			cy_s1    <= in_cy;
			bw_s1    <= in_bw;
			bh_s1    <= in_bh;
			score_s1 <= best_nx;
			cls_s1   <= cls_nx;
		end
		if (ctl.ld_s2) begin
			score_s2 <= score_s1;
			cls_s2   <= cls_s1;
		end
		if (ctl.ld_s3) begin
			score_s3 <= score_s2;
			cls_s3   <= cls_s2;
		end
		if (ctl.ld_out) begin
			score_q <= score_s3;
			cls_q   <= cls_s3;
		end
	end

	logic [dbd_pkg::EDGE_W-1:0] left_q, top_q;
	logic [dbd_pkg::LEN_W-1:0]  width_q, height_q;

	dbd_axis u_axis_x (
		.clk      (clk),
		.ctl      (ctl),
		.center   (cx_s1),
		.size     (bw_s1),
		.scale    (scale_x_q),
		.frame    (frame_w_q),
		.edge_pos (left_q),
		.length   (width_q)
	);

	dbd_axis u_axis_y (
		.clk      (clk),
		.ctl      (ctl),
		.center   (cy_s1),
		.size     (bh_s1),
		.scale    (scale_y_q),
		.frame    (frame_h_q),
		.edge_pos (top_q),
		.length   (height_q)
	);

	assign m_tvalid = vo_q;
	assign m_tdata  = {3'b0, dbd_pkg::CLASS_ID_W'(cls_q), score_q,
	                   height_q, width_q, top_q, left_q};

	// checks
	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> v1_q)
		else $error("input stalled with first stage empty");

	a_pass_loads: assert property (@(posedge clk) disable iff (!arst_n)
		acc && s_tlast && pass |=> v1_q)
		else $error("passing box did not enter pipeline");

	a_box_clears: assert property (@(posedge clk) disable iff (!arst_n)
		acc && s_tlast |=> best_q == '0 && cnt_q == '0 && best_cls_q == '0)
		else $error("argmax not cleared after last class");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_LAST && best_cls_q <= CNT_LAST)
		else $error("class counter out of range");

	a_out_above_limit: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.ld_out |=> score_q != '0)
		else $error("result with zero score");

endmodule
